// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// ----- rtl/core/smshex_pkg.sv -----
`timescale 1ns / 1ps
package smshex_pkg;

   typedef enum logic [1:0] {
      MODE_SEVEN = 2'd0,
      MODE_OCTET = 2'd1,
      MODE_UCS2  = 2'd2
   } coding_type;

   localparam logic [6:0] ERR_CHAR = 7'h30;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic [6:0] hex_char;
      logic       end_of_message;
      logic       bad_utf8;
   } rsp_word_type;

   // one classified input byte: up to four octets, or one error char
   typedef struct packed {
      logic [3:0][7:0] octets;   // octets[0] goes out first
      logic [1:0]      noct_m1;  // octet count minus one
      logic            bad;
      logic            eom;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

   function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
      logic [6:0] n7;
      n7 = {3'b000, nib};
      if (nib < 4'd10) return 7'h30 + n7;
      else             return 7'h37 + n7;
   endfunction

endpackage

// ----- rtl/core/smshex_front.sv -----
`timescale 1ns / 1ps
module smshex_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  smshex_pkg::req_word_type    req_word,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_data,
   input  smshex_pkg::q_status_type    q_status,
   output logic                        push,
   output smshex_pkg::job_type         push_job
);
   import smshex_pkg::*;

   coding_type  mode_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [6:0]  resid_ff, resid_in;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  left_ff, left_in;
   logic [1:0]  len_ff, len_in;

   logic        accept;
   logic        has_out;
   job_type     job;
   logic [7:0]  b;
   logic        fin;
   logic [14:0] shifted;
   logic        cp_emit;
   logic [20:0] cp_val;
   logic [20:0] cp_sub;
   logic [20:0] acc_nx;
   logic [1:0]  left_nx;
   logic        cp_bad;
   logic        err;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept && has_out;
   assign push_job  = job;
   assign b         = req_word.text_byte;
   assign fin       = req_word.final_byte;
   assign cp_sub    = cp_val - 21'h010000;

   always_comb begin
      phase_in = phase_ff;
      resid_in = resid_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      len_in   = len_ff;
      has_out  = 1'b0;
      job      = '0;
      job.eom  = fin;
      shifted  = '0;
      cp_emit  = 1'b0;
      cp_val   = '0;
      acc_nx   = '0;
      left_nx  = '0;
      cp_bad   = 1'b0;
      err      = 1'b0;

      case (mode_ff)
         MODE_SEVEN: begin
            // pack septets lsb first
            shifted = {b[6:0], 8'h00} >> phase_ff;
            if (phase_ff == 3'd0) begin
               resid_in = b[6:0];
            end else begin
               has_out        = 1'b1;
               job.octets[0]  = shifted[7:0] | {1'b0, resid_ff};
               resid_in       = b[6:0] >> phase_ff;
            end
            phase_in = phase_ff + 3'd1;
            // flush leftover bits behind a trailing nul septet
            if (fin && phase_in != 3'd0) begin
               if (has_out) begin
                  job.octets[1] = {1'b0, resid_in};
                  job.noct_m1   = 2'd1;
               end else begin
                  job.octets[0] = {1'b0, resid_in};
                  job.noct_m1   = 2'd0;
               end
               has_out = 1'b1;
            end
         end
         MODE_UCS2: begin
            if (left_ff == 2'd0) begin
               if (b < 8'h80) begin
                  cp_emit = 1'b1;
                  cp_val  = {13'b0, b};
               end else if (b inside {[8'hC2:8'hDF]}) begin
                  acc_in  = {16'b0, b[4:0]};
                  left_in = 2'd1;
                  len_in  = 2'd1;
               end else if (b inside {[8'hE0:8'hEF]}) begin
                  acc_in  = {17'b0, b[3:0]};
                  left_in = 2'd2;
                  len_in  = 2'd2;
               end else if (b inside {[8'hF0:8'hF4]}) begin
                  acc_in  = {18'b0, b[2:0]};
                  left_in = 2'd3;
                  len_in  = 2'd3;
               end else begin
                  err = 1'b1;
               end
            end else if (b[7:6] != 2'b10) begin
               err = 1'b1;
            end else begin
               acc_nx  = {acc_ff[14:0], b[5:0]};
               left_nx = left_ff - 2'd1;
               if (left_nx == 2'd0) begin
                  // overlong, surrogate or out of range
                  if (len_ff == 2'd2 && (acc_nx < 21'h000800 ||
                      (acc_nx >= 21'h00D800 && acc_nx <= 21'h00DFFF)))
                     cp_bad = 1'b1;
                  if (len_ff == 2'd3 && (acc_nx < 21'h010000 || acc_nx > 21'h10FFFF))
                     cp_bad = 1'b1;
                  acc_in  = '0;
                  left_in = '0;
                  len_in  = '0;
                  if (cp_bad) begin
                     err = 1'b1;
                  end else begin
                     cp_emit = 1'b1;
                     cp_val  = acc_nx;
                  end
               end else begin
                  acc_in  = acc_nx;
                  left_in = left_nx;
               end
            end
            // truncated sequence at end of message
            if (fin && left_in != 2'd0) err = 1'b1;
            if (err) begin
               acc_in  = '0;
               left_in = '0;
               len_in  = '0;
               has_out = 1'b1;
               job.bad = 1'b1;
            end
            if (cp_emit) begin
               has_out = 1'b1;
               if (cp_val >= 21'h010000) begin
                  job.octets[0] = {6'b110110, cp_sub[19:18]};
                  job.octets[1] = cp_sub[17:10];
                  job.octets[2] = {6'b110111, cp_sub[9:8]};
                  job.octets[3] = cp_sub[7:0];
                  job.noct_m1   = 2'd3;
               end else begin
                  job.octets[0] = cp_val[15:8];
                  job.octets[1] = cp_val[7:0];
                  job.noct_m1   = 2'd1;
               end
            end
         end
         default: begin
            // eight-bit copy, also the unused mode code
            has_out       = 1'b1;
            job.octets[0] = b;
         end
      endcase

      if (fin) begin
         phase_in = '0;
         resid_in = '0;
         acc_in   = '0;
         left_in  = '0;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SEVEN;
         phase_ff <= '0;
         resid_ff <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         len_ff   <= '0;
      end else begin
         if (csr_write) mode_ff <= coding_type'(csr_data);
         if (accept) begin
            phase_ff <= phase_in;
            resid_ff <= resid_in;
            acc_ff   <= acc_in;
            left_ff  <= left_in;
            len_ff   <= len_in;
         end
      end
   end

endmodule

// ----- rtl/core/smshex_fifo.sv -----
`timescale 1ns / 1ps
module smshex_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  smshex_pkg::job_type       push_job,
   input  logic                      pop,
   output smshex_pkg::q_status_type  q_status,
   output smshex_pkg::job_type       head_job
);
   import smshex_pkg::*;

   localparam int DEPTH = 2;

   job_type    mem_ff [DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign q_status.not_empty = (count_ff != 2'd0);
   assign q_status.full      = (count_ff == 2'(DEPTH));
   assign head_job           = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/smshex_back.sv -----
`timescale 1ns / 1ps
module smshex_back (
   input  logic                      clock,
   input  logic                      reset,
   input  smshex_pkg::q_status_type  q_status,
   input  smshex_pkg::job_type       head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output smshex_pkg::rsp_word_type  rsp_word
);
   import smshex_pkg::*;

   logic         busy_ff, busy_in;
   job_type      job_ff;
   logic [2:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic       emit;
   logic       last_char;
   logic [2:0] last_idx;
   logic [7:0] cur_octet;
   logic [3:0] cur_nib;

   assign last_idx  = job_ff.bad ? 3'd0 : {job_ff.noct_m1, 1'b1};
   assign last_char = (idx_ff == last_idx);
   assign emit      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop       = q_status.not_empty && (!busy_ff || (emit && last_char));
   assign cur_octet = job_ff.octets[idx_ff[2:1]];
   assign cur_nib   = idx_ff[0] ? cur_octet[3:0] : cur_octet[7:4];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (emit) begin
         busy_in = !last_char;
         idx_in  = idx_ff + 3'd1;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_word_in.hex_char       = job_ff.bad ? ERR_CHAR : hex_ascii(cur_nib);
         rsp_word_in.end_of_message = job_ff.eom && last_char;
         rsp_word_in.bad_utf8       = job_ff.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= head_job;
      rsp_word_ff <= rsp_word_in;
      idx_ff      <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/sms_user_data_hex_encoder.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake             | word
// req      | in        | req_valid / req_stall | text_byte, final_byte
// rsp      | out       | rsp_valid / rsp_stall | hex_char, end_of_message, bad_utf8
// csr      | in        | csr_write             | coding_mode in csr_data
//
// at most one hex char leaves per cycle; the chars a byte makes are:
// 0 to 4 in seven-bit mode, 2 in eight-bit copy, 0, 1, 4 or 8 in ucs2 mode
// the rsp output register sets that rate: one char a cycle while rsp_stall is low
// a byte is accepted whenever the two-entry job queue has room
// reset is synchronous and clears the mode, the coding state, queue and output
// rsp_stall holds the output char; req_stall rises only when the queue is full
module sms_user_data_hex_encoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  smshex_pkg::req_word_type  req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output smshex_pkg::rsp_word_type  rsp_word,
   input  logic                      csr_write,
   input  logic [1:0]                csr_data
);
   import smshex_pkg::*;

   // front to queue
   logic         push;
   job_type      push_job;
   // queue to back
   q_status_type q_status;
   job_type      head_job;
   logic         pop;

   // front: holds the mode and the septet and utf-8 state, turns one byte
   // into at most one job of up to four octets or one error char
   smshex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // short queue so the front keeps taking bytes while chars drain
   smshex_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_status (q_status),
      .head_job (head_job)
   );

   // back: walks the job nibble by nibble, high nibble first, into the
   // registered output stage
   smshex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/core/smshex_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smshex_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  smshex_pkg::req_word_type  req_word,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  smshex_pkg::rsp_word_type  rsp_word
);
   import smshex_pkg::*;

   logic err_char_ok;
   logic hex_char_ok;

   assign err_char_ok = (rsp_word.hex_char == ERR_CHAR);
   // upper-case hex digit
   assign hex_char_ok = (rsp_word.hex_char >= 7'h30 && rsp_word.hex_char <= 7'h39) ||
                        (rsp_word.hex_char >= 7'h41 && rsp_word.hex_char <= 7'h46);

   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_word))
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_word))
   `ASSERT_IMPLY(a_err_char, clock, reset, rsp_valid && rsp_word.bad_utf8, err_char_ok)
   `ASSERT_IMPLY(a_hex_range, clock, reset, rsp_valid && !rsp_word.bad_utf8, hex_char_ok)

endmodule

bind sms_user_data_hex_encoder smshex_checker u_checker (.*);

// ----- tb/tb_sms_user_data_hex_encoder.sv -----
`timescale 1ns / 1ps
module tb_sms_user_data_hex_encoder;
   import smshex_pkg::*;

   // mode three is not in the package enum; the block treats it as a plain copy
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // digit table, most significant character first
   localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";
   // the filler char sent along with a bad_utf8 word
   localparam logic [6:0] BAD_CHAR = 7'h30;
   // two queued jobs plus the output register, with margin
   localparam int DRAIN_CYCLES = 24;
   localparam int TAIL_CYCLES = 40;

   // how the expected words of one input byte are produced
   typedef enum logic [1:0] {
      GOLD_PREDICT = 2'd0,   // from the predictor
      GOLD_HEX     = 2'd1,   // typed in: nibbles of hex, low len of them
      GOLD_ERROR   = 2'd2    // typed in: one bad_utf8 word
   } gold_kind_type;

   typedef struct packed {
      gold_kind_type kind;
      logic [15:0]   hex;
      logic [2:0]    len;
   } gold_type;

   typedef enum logic {
      ROW_MODE = 1'b0,   // write coding_mode
      ROW_BYTE = 1'b1    // send one text byte
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   mode;
      logic [7:0]   text;
      logic         last;
      gold_type     gold;
   } stim_row_type;

   localparam gold_type NO_GOLD = '{GOLD_PREDICT, 16'h0000, 3'd0};

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   logic         csr_write;
   logic [1:0]   csr_data;

   // idle rates in percent, changed per phase
   int gap_pct  = 22;
   int hold_pct = 81;
   int err_count = 0;

   // predictor copy of the register and the coding state
   logic [1:0]  coding_now   = MODE_SEVEN;
   logic [2:0]  septet_ph    = '0;
   logic [6:0]  leftover     = '0;
   logic [20:0] cp_sofar     = '0;
   logic [1:0]  conts_due    = '0;
   logic [1:0]  seq_kind     = '0;

   rsp_word_type fresh_chars[$];     // words of the byte just predicted
   rsp_word_type hex_chars_due[$];   // expected rsp words, oldest first
   gold_type     bytes_in_flight[$]; // presented req words not yet accepted
   logic [7:0]   utf8_seq[$];        // scratch for one random utf-8 sequence
   stim_row_type script[$];

   sms_user_data_hex_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      return HEX_DIGITS[8*(15-nib) +: 7];
   endfunction

   function automatic void add_char(input logic [6:0] ch, input logic bad);
      rsp_word_type w;
      w.hex_char       = ch;
      w.end_of_message = 1'b0;
      w.bad_utf8       = bad;
      fresh_chars.push_back(w);
   endfunction

   function automatic void add_octet(input logic [7:0] o);
      add_char(hex_digit(o[7:4]), 1'b0);
      add_char(hex_digit(o[3:0]), 1'b0);
   endfunction

   function automatic void add_unit(input logic [15:0] u);
      add_octet(u[15:8]);
      add_octet(u[7:0]);
   endfunction

   // utf-16 big endian, surrogate pair above the basic plane
   function automatic void add_code_point(input logic [20:0] cp);
      logic [20:0] v;
      if (cp >= 21'h10000) begin
         v = cp - 21'h10000;
         add_unit(16'hD800 | {6'd0, v[19:10]});
         add_unit(16'hDC00 | {6'd0, v[9:0]});
      end else begin
         add_unit(cp[15:0]);
      end
   endfunction

   function automatic void drop_decoder();
      cp_sofar  = '0;
      conts_due = '0;
      seq_kind  = '0;
   endfunction

   // lsb-first septet packing, bit 7 of the byte is ignored
   function automatic void pack_septet(input logic [7:0] b);
      logic [6:0]  c;
      logic [15:0] wide;
      c = b[6:0];
      if (septet_ph == 3'd0) begin
         leftover = c;
      end else begin
         wide = ({9'd0, c} << (4'd8 - {1'b0, septet_ph})) | {9'd0, leftover};
         add_octet(wide[7:0]);
         leftover = c >> septet_ph;
      end
      septet_ph = septet_ph + 3'd1;
   endfunction

   function automatic void decode_utf8(input logic [7:0] b);
      logic [20:0] cp;
      logic        bad;
      if (conts_due == 2'd0) begin
         if (b < 8'h80) begin
            add_code_point({13'd0, b});
         end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cp_sofar  = {16'd0, b[4:0]};
            conts_due = 2'd1;
            seq_kind  = 2'd1;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cp_sofar  = {17'd0, b[3:0]};
            conts_due = 2'd2;
            seq_kind  = 2'd2;
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cp_sofar  = {18'd0, b[2:0]};
            conts_due = 2'd3;
            seq_kind  = 2'd3;
         end else begin
            // bad lead byte
            drop_decoder();
            add_char(BAD_CHAR, 1'b1);
         end
      end else if (b[7:6] != 2'b10) begin
         // continuation missing, offending byte is dropped
         drop_decoder();
         add_char(BAD_CHAR, 1'b1);
      end else begin
         cp_sofar  = {cp_sofar[14:0], b[5:0]};
         conts_due = conts_due - 2'd1;
         if (conts_due == 2'd0) begin
            cp  = cp_sofar;
            bad = 1'b0;
            // overlong three-byte form or a surrogate value
            if (seq_kind == 2'd2 && (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)))
               bad = 1'b1;
            // overlong four-byte form or beyond the last plane
            if (seq_kind == 2'd3 && (cp < 21'h10000 || cp > 21'h10FFFF))
               bad = 1'b1;
            drop_decoder();
            if (bad) add_char(BAD_CHAR, 1'b1);
            else     add_code_point(cp);
         end
      end
   endfunction

   // fills fresh_chars with the rsp words one req word causes
   function automatic void predict_hex_chars(input req_word_type w);
      fresh_chars.delete();
      case (coding_now)
         MODE_SEVEN: begin
            pack_septet(w.text_byte);
            // flush: a nul septet pushes out the leftover bits
            if (w.final_byte && septet_ph != 3'd0) add_octet({1'b0, leftover});
         end
         MODE_UCS2: begin
            decode_utf8(w.text_byte);
            // message ends inside a sequence
            if (w.final_byte && conts_due != 2'd0) begin
               drop_decoder();
               add_char(BAD_CHAR, 1'b1);
            end
         end
         default: add_octet(w.text_byte);   // eight-bit copy, mode three too
      endcase
      if (w.final_byte) begin
         septet_ph = '0;
         leftover  = '0;
         drop_decoder();
         if (fresh_chars.size() > 0) fresh_chars[fresh_chars.size()-1].end_of_message = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------- monitor

   // req acceptance feeds the expectations, rsp acceptance is checked against them
   always @(posedge clock) begin
      gold_type     g;
      req_word_type took;
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            took = req_word;
            g = NO_GOLD;
            if (bytes_in_flight.size() > 0) g = bytes_in_flight.pop_front();
            predict_hex_chars(took);
            // typed rows replace the predicted words, state still advances
            if (g.kind != GOLD_PREDICT) begin
               fresh_chars.delete();
               if (g.kind == GOLD_ERROR) add_char(BAD_CHAR, 1'b1);
               else
                  for (int i = int'(g.len) - 1; i >= 0; i--)
                     add_char(hex_digit(g.hex[4*i +: 4]), 1'b0);
               if (took.final_byte && fresh_chars.size() > 0)
                  fresh_chars[fresh_chars.size()-1].end_of_message = 1'b1;
            end
            foreach (fresh_chars[i]) hex_chars_due.push_back(fresh_chars[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (hex_chars_due.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected rsp word: char %h eom %b bad %b",
                           rsp_word.hex_char, rsp_word.end_of_message, rsp_word.bad_utf8);
            end else begin
               want = hex_chars_due.pop_front();
               if (rsp_word.hex_char !== want.hex_char ||
                   rsp_word.end_of_message !== want.end_of_message ||
                   rsp_word.bad_utf8 !== want.bad_utf8) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("rsp mismatch: expected char %h eom %b bad %b, got char %h eom %b bad %b",
                              want.hex_char, want.end_of_message, want.bad_utf8,
                              rsp_word.hex_char, rsp_word.end_of_message, rsp_word.bad_utf8);
               end
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < hold_pct);

   // ---------------------------------------------------------------- stimulus

   // one req word; valid stays up into the next word unless a gap is drawn
   task automatic send_text_byte(input logic [7:0] b, input logic fin, input gold_type g);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= req_word_type'({b, fin});
      bytes_in_flight.push_back(g);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // mode writes only with nothing in flight and the job queue drained
   task automatic set_coding(input logic [1:0] m);
      req_valid <= 1'b0;
      while (bytes_in_flight.size() != 0 || hex_chars_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write  <= 1'b1;
      csr_data   <= m;
      coding_now  = m;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // utf-8 form of cp in nb bytes, nb forced so overlong forms can be built
   function automatic void encode_utf8(input logic [20:0] cp, input int nb);
      case (nb)
         1: utf8_seq.push_back({1'b0, cp[6:0]});
         2: begin
            utf8_seq.push_back({3'b110, cp[10:6]});
            utf8_seq.push_back({2'b10, cp[5:0]});
         end
         3: begin
            utf8_seq.push_back({4'b1110, cp[15:12]});
            utf8_seq.push_back({2'b10, cp[11:6]});
            utf8_seq.push_back({2'b10, cp[5:0]});
         end
         default: begin
            utf8_seq.push_back({5'b11110, cp[20:18]});
            utf8_seq.push_back({2'b10, cp[17:12]});
            utf8_seq.push_back({2'b10, cp[11:6]});
            utf8_seq.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   task automatic send_plain_burst(input int n);
      for (int i = 0; i < n; i++)
         send_text_byte(8'($urandom_range(255)), ($urandom_range(9) == 0), NO_GOLD);
   endtask

   // mostly well-formed sequences, some noise, illegal and cut-short ones
   task automatic send_ucs2_burst(input int n);
      int          sent;
      int unsigned pick;
      logic [20:0] cp;
      logic [7:0]  junk;
      int          spot;
      logic        cut_short;
      logic        fin;
      sent = 0;
      while (sent < n) begin
         utf8_seq.delete();
         cut_short = 1'b0;
         pick = $urandom_range(15);
         if (pick < 3) begin
            encode_utf8(21'($urandom_range(8'h7F)), 1);
         end else if (pick < 6) begin
            encode_utf8(21'($urandom_range(16'h7FF, 16'h80)), 2);
         end else if (pick < 9) begin
            cp = 21'($urandom_range(16'hFFFF, 16'h800));
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h1000;
            encode_utf8(cp, 3);
         end else if (pick < 11) begin
            encode_utf8(21'($urandom_range(21'h10FFFF, 21'h10000)), 4);
         end else if (pick == 11) begin
            utf8_seq.push_back(8'($urandom_range(255)));
         end else if (pick == 12) begin
            // leads that can never start a legal sequence
            if ($urandom_range(1)) utf8_seq.push_back(8'hC0 | 8'($urandom_range(1)));
            else                   utf8_seq.push_back(8'($urandom_range(255, 8'hF5)));
         end else if (pick == 13) begin
            // complete in shape but illegal in value
            case ($urandom_range(3))
               0: encode_utf8(21'($urandom_range(16'h7FF)), 3);
               1: encode_utf8(21'($urandom_range(16'hFFFF)), 4);
               2: encode_utf8(21'($urandom_range(16'hDFFF, 16'hD800)), 3);
               default: encode_utf8(21'($urandom_range(21'h13FFFF, 21'h110000)), 4);
            endcase
         end else if (pick == 14) begin
            // a continuation replaced by a non-continuation byte
            encode_utf8(21'($urandom_range(21'h10FFFF, 21'h10000)), 3 + $urandom_range(1));
            junk = 8'($urandom_range(255));
            if (junk[7:6] == 2'b10) junk[6] = 1'b1;
            spot = $urandom_range(utf8_seq.size() - 1, 1);
            utf8_seq[spot] = junk;
         end else begin
            // message ends before the sequence does
            encode_utf8(21'($urandom_range(21'h10FFFF, 21'h80)), 2 + $urandom_range(2));
            spot = $urandom_range(utf8_seq.size() - 1, 1);
            while (utf8_seq.size() > spot) void'(utf8_seq.pop_back());
            cut_short = 1'b1;
         end
         foreach (utf8_seq[i]) begin
            fin = (i == utf8_seq.size() - 1) && (cut_short || $urandom_range(7) == 0);
            send_text_byte(utf8_seq[i], fin, NO_GOLD);
            sent++;
         end
      end
   endtask

   function automatic stim_row_type byte_row(input logic [7:0] b, input logic fin,
                                             input gold_kind_type k = GOLD_PREDICT,
                                             input logic [15:0] hex = '0,
                                             input logic [2:0] len = '0);
      stim_row_type r;
      r.kind = ROW_BYTE;
      r.mode = MODE_SEVEN;
      r.text = b;
      r.last = fin;
      r.gold = '{k, hex, len};
      return r;
   endfunction

   function automatic stim_row_type mode_row(input logic [1:0] m);
      stim_row_type r;
      r = byte_row(8'h00, 1'b0);
      r.kind = ROW_MODE;
      r.mode = m;
      return r;
   endfunction

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_data  <= '0;

      // seven-bit mode from reset: single septet flushed as one octet
      script.push_back(byte_row(8'h41, 1'b1, GOLD_HEX, 16'h0041, 3'd2));
      // bit 7 must be masked, then a two-octet message with flush
      script.push_back(byte_row(8'hFF, 1'b0));
      script.push_back(byte_row(8'h00, 1'b1));
      // eight-bit copy at the top of the byte range
      script.push_back(mode_row(MODE_OCTET));
      script.push_back(byte_row(8'hFF, 1'b1, GOLD_HEX, 16'h00FF, 3'd2));
      // mode three copies like eight-bit mode
      script.push_back(mode_row(MODE_SPARE));
      script.push_back(byte_row(8'hA5, 1'b1, GOLD_HEX, 16'h00A5, 3'd2));
      script.push_back(mode_row(MODE_UCS2));
      // nul byte is a real code point
      script.push_back(byte_row(8'h00, 1'b0, GOLD_HEX, 16'h0000, 3'd4));
      // two-byte and four-byte (surrogate pair) sequences
      script.push_back(byte_row(8'hC3, 1'b0));
      script.push_back(byte_row(8'hA9, 1'b0));
      script.push_back(byte_row(8'hF0, 1'b0));
      script.push_back(byte_row(8'h9F, 1'b0));
      script.push_back(byte_row(8'h98, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      // bad lead byte
      script.push_back(byte_row(8'hFF, 1'b0, GOLD_ERROR));
      // overlong three-byte form
      script.push_back(byte_row(8'hE0, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      // surrogate value
      script.push_back(byte_row(8'hED, 1'b0));
      script.push_back(byte_row(8'hA0, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      // above the last plane
      script.push_back(byte_row(8'hF4, 1'b0));
      script.push_back(byte_row(8'h90, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0));
      // missing continuation, the ascii byte is swallowed
      script.push_back(byte_row(8'hE2, 1'b0));
      script.push_back(byte_row(8'h41, 1'b0, GOLD_ERROR));
      // message ends inside a sequence
      script.push_back(byte_row(8'hC3, 1'b1, GOLD_ERROR));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_MODE) set_coding(script[i].mode);
         else send_text_byte(script[i].text, script[i].last, script[i].gold);
      end

      // random part: receiver-heavy idling, then sender-heavy, then none
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct  = (ph == 0) ? 22 : (ph == 1) ? 81 : 0;
         hold_pct = (ph == 0) ? 81 : (ph == 1) ? 22 : 0;
         // writes land mid-message too, each mode keeps its own state
         set_coding(MODE_UCS2);
         send_ucs2_burst(80);
         set_coding(MODE_SEVEN);
         send_plain_burst(50);
         set_coding(MODE_OCTET);
         send_plain_burst(20);
         set_coding(MODE_SPARE);
         send_plain_burst(15);
      end

      req_valid <= 1'b0;
      while (bytes_in_flight.size() != 0 || hex_chars_due.size() != 0) @(posedge clock);
      // catch any stray word after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/smshex_pkg.sv
rtl/core/smshex_front.sv
rtl/core/smshex_fifo.sv
rtl/core/smshex_back.sv
rtl/core/sms_user_data_hex_encoder.sv
rtl/core/smshex_checker.sv
tb/tb_sms_user_data_hex_encoder.sv
